>>> sv/interval_range_map_core_defines.svh
// Assertion macros for the interval range map core
`ifndef INTERVAL_RANGE_MAP_CORE_DEFINES_SVH
`define INTERVAL_RANGE_MAP_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted
`define IRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define IRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/irm_pkg.sv
// Shared types and constants of the interval range map core
`timescale 1ns / 1ps
package irm_pkg;

  localparam int unsigned OUT_VALUE_BITS = 32;

  localparam logic ACTION_ASSIGN = 1'b0;
  localparam logic ACTION_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } irm_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SEV,
    S_FIT,
    S_WA,
    S_WB,
    S_CRD,
    S_CEV,
    S_FIN,
    S_DONE
  } irm_state_e;

endpackage

>>> sv/irm_if.sv
// Request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface irm_req_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [KEY_BITS-1:0]   key_first;
  logic [KEY_BITS-1:0]   key_last;
  logic [VALUE_BITS-1:0] fill_value;

  modport source (output valid, action, key_first, key_last, fill_value, input ready);
  modport sink   (input valid, action, key_first, key_last, fill_value, output ready);
endinterface

interface irm_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [irm_pkg::OUT_VALUE_BITS-1:0]    lookup_value;
  logic [1:0]                            status;

  modport source (output valid, lookup_value, status, input ready);
  modport sink   (input valid, lookup_value, status, output ready);
endinterface

interface irm_cfg_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] default_value;

  modport source (output valid, default_value, input ready);
  modport sink   (input valid, default_value, output ready);
endinterface

>>> sv/irm_bank.sv
// One bank of boundary entries: single write port, registered read
`timescale 1ns / 1ps
module irm_bank #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/interval_range_map_core.sv
// Top level of the interval range map core
//
// Holds a sorted table of interval boundaries in two ping-pong banks.
// Channels: req_i takes assign (action 0) and lookup (action 1) transactions,
// rsp_o returns one result per request, cfg_i writes default_value, which
// empties the table. All use valid/ready; a transaction moves when both are
// high. cfg_i is only ready while no request is in flight.
// A request scans the current bank one entry at a time: S_SRD reads it (the
// bank read is registered) and S_SEV evaluates it. An assign then writes up
// to two new boundaries and copies the tail into the other bank, again one
// entry at a time, and flips banks. An empty interval goes straight to the
// result. One request is worked on at a time. The result sits in an output
// register, so the next request is accepted while a result waits; a stalled
// receiver only blocks the block once a second result is ready.
// Reset empties the table and sets the lowest value to zero; bank contents
// are never read before written.
`timescale 1ns / 1ps
`include "interval_range_map_core_defines.svh"
module interval_range_map_core #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  irm_req_if.sink   req_i,
  irm_rsp_if.source rsp_o,
  irm_cfg_if.sink   cfg_i
);
  import irm_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = KEY_BITS + VALUE_BITS;

  irm_state_e state_q, state_d;

  logic                  bank_q;
  logic [CW-1:0]         cnt_q;
  logic [VALUE_BITS-1:0] lowest_q;
  logic                  act_q;
  logic [KEY_BITS-1:0]   a_q, b_q;
  logic [VALUE_BITS-1:0] v_q, prev_q, endv_q;
  logic [CW-1:0]         idx_q, lo_q, nle_q, wptr_q;
  logic [CW:0]           n_q;
  logic                  need_a_q, need_b_q;
  logic [VALUE_BITS-1:0] res_val_q;
  irm_status_e           res_st_q;
  logic                  ov_q;
  logic [OUT_VALUE_BITS-1:0] ov_val_q;
  irm_status_e           ov_st_q;

  logic [DW-1:0]         rdata0, rdata1, rdata;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic                  we;
  logic [DW-1:0]         wdata;
  logic                  need_a, need_b;
  logic [CW:0]           n_calc;
  logic                  out_load;
  logic                  last_idx;

  assign rdata    = bank_q ? rdata1 : rdata0;
  assign rkey     = rdata[DW-1:VALUE_BITS];
  assign rval     = rdata[VALUE_BITS-1:0];
  assign last_idx = (idx_q + CW'(1)) == cnt_q;
  assign need_a   = v_q != prev_q;
  assign need_b   = endv_q != v_q;
  assign n_calc   = (CW+1)'(lo_q) + (CW+1)'(need_a) + (CW+1)'(need_b)
                  + (CW+1)'(cnt_q - nle_q);
  assign out_load = (state_q == S_DONE) && (!ov_q || rsp_o.ready);

  irm_bank #(.DEPTH(TABLE_DEPTH), .WIDTH(DW)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we && bank_q),
    .waddr_i (wptr_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata0)
  );

  irm_bank #(.DEPTH(TABLE_DEPTH), .WIDTH(DW)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we && !bank_q),
    .waddr_i (wptr_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata1)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.action == ACTION_LOOKUP) begin
            state_d = (cnt_q != '0) ? S_SRD : S_DONE;
          end else if (req_i.key_first >= req_i.key_last) begin
            state_d = S_DONE;
          end else begin
            state_d = (cnt_q != '0) ? S_SRD : S_FIT;
          end
        end
      end
      S_SRD: state_d = S_SEV;
      S_SEV: begin
        if (last_idx) begin
          state_d = (act_q == ACTION_LOOKUP) ? S_DONE : S_FIT;
        end else begin
          state_d = S_SRD;
        end
      end
      S_FIT: state_d = (n_calc > (CW+1)'(TABLE_DEPTH)) ? S_DONE : S_WA;
      S_WA:  state_d = S_WB;
      S_WB:  state_d = (nle_q < cnt_q) ? S_CRD : S_FIN;
      S_CRD: state_d = S_CEV;
      S_CEV: state_d = last_idx ? S_FIN : S_CRD;
      S_FIN: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_i.ready = 1'b0;
    cfg_i.ready = 1'b0;
    we          = 1'b0;
    wdata       = rdata;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        cfg_i.ready = !req_i.valid;
      end
      S_SEV: we = (act_q == ACTION_ASSIGN) && (rkey < a_q);
      S_WA: begin
        we    = need_a_q;
        wdata = {a_q, v_q};
      end
      S_WB: begin
        we    = need_b_q;
        wdata = {b_q, endv_q};
      end
      S_CEV: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bank_q   <= 1'b0;
      cnt_q    <= '0;
      lowest_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        lowest_q <= cfg_i.default_value;
        cnt_q    <= '0;
      end
      if (state_q == S_FIN) begin
        bank_q <= !bank_q;
        cnt_q  <= n_q[CW-1:0];
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        act_q    <= req_i.action;
        a_q      <= req_i.key_first;
        b_q      <= (req_i.action == ACTION_LOOKUP) ? req_i.key_first : req_i.key_last;
        v_q      <= req_i.fill_value;
        prev_q   <= lowest_q;
        endv_q   <= lowest_q;
        idx_q    <= '0;
        lo_q     <= '0;
        nle_q    <= '0;
        wptr_q   <= '0;
        res_val_q <= (req_i.action == ACTION_LOOKUP) ? lowest_q : '0;
        res_st_q <= (req_i.action == ACTION_ASSIGN && req_i.key_first >= req_i.key_last)
                    ? STATUS_EMPTY : STATUS_DONE;
      end
      S_SEV: begin
        // keys ascend, so both counts are prefix lengths
        if (rkey < a_q) begin
          prev_q <= rval;
          lo_q   <= idx_q + CW'(1);
          wptr_q <= idx_q + CW'(1);
        end
        if (rkey <= b_q) begin
          endv_q <= rval;
          nle_q  <= idx_q + CW'(1);
          if (act_q == ACTION_LOOKUP) begin
            res_val_q <= rval;
          end
        end
        idx_q <= idx_q + CW'(1);
      end
      S_FIT: begin
        need_a_q <= need_a;
        need_b_q <= need_b;
        n_q      <= n_calc;
        if (n_calc > (CW+1)'(TABLE_DEPTH)) begin
          res_st_q <= STATUS_FULL;
        end
      end
      S_WA: begin
        if (need_a_q) begin
          wptr_q <= wptr_q + CW'(1);
        end
      end
      S_WB: begin
        if (need_b_q) begin
          wptr_q <= wptr_q + CW'(1);
        end
        idx_q <= nle_q;
      end
      S_CEV: begin
        wptr_q <= wptr_q + CW'(1);
        idx_q  <= idx_q + CW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      ov_val_q <= OUT_VALUE_BITS'(res_val_q);
      ov_st_q  <= res_st_q;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.lookup_value = ov_val_q;
  assign rsp_o.status       = ov_st_q;

  `IRM_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(TABLE_DEPTH),
    "boundary count beyond table depth")
  `IRM_ASSERT_NEXT(a_full_keeps_bank, clk_i, rst_ni,
    (state_q == S_FIT) && (n_calc > (CW+1)'(TABLE_DEPTH)),
    (bank_q == $past(bank_q)) && (res_st_q == STATUS_FULL),
    "rejected assign changed the table")
  `IRM_ASSERT_NEXT(a_fin_flips, clk_i, rst_ni, state_q == S_FIN,
    (bank_q != $past(bank_q)) && (state_q == S_DONE),
    "bank not flipped after assign")
  `IRM_ASSERT_NOW(a_cfg_idle, clk_i, rst_ni, cfg_i.valid && cfg_i.ready,
    (state_q == S_IDLE) && !req_i.valid,
    "configuration written during a request")
endmodule
